FILE: hw/rtl/fpi_pkg.sv
`default_nettype none

package fpi_pkg;

    localparam int POS_W = 16;
    localparam int SHIFT_W = 5;
    localparam logic [SHIFT_W-1:0] PERIOD_SHIFT_RESET = 5'd8;

    typedef struct packed {
        logic                    new_target_valid;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    arrived;
    } out_item_t;

    typedef struct packed {
        logic step_en;
        logic load;
    } axis_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fpi_axis.sv
`default_nettype none

module fpi_axis
    import fpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire axis_ctrl_t              ctrl,
    input  wire logic signed [POS_W-1:0] target,
    input  wire logic [SHIFT_W-1:0]      shift,
    output logic signed [POS_W-1:0]      pos,
    output logic                         done
);

    localparam int ACC_W = POS_W + FRAC_BITS;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [POS_W-1:0] end_reg;
    logic [ACC_W-1:0]        step_reg;
    logic                    up_reg;

    logic signed [POS_W-1:0] end_use;
    logic signed [ACC_W-1:0] tgt_fix;
    logic signed [ACC_W:0]   diff;
    logic signed [ACC_W:0]   mag;
    logic                    up_new;
    logic [ACC_W-1:0]        step_new;
    logic                    up_use;
    logic [ACC_W-1:0]        step_use;
    logic signed [ACC_W+1:0] step_ext;
    logic signed [ACC_W+1:0] sum;
    logic signed [ACC_W+1:0] tgt_ext;

    // distance and direction toward a freshly loaded end point
    always_comb
    begin
        end_use  = ctrl.load ? target : end_reg;
        tgt_fix  = {end_use, {FRAC_BITS{1'b0}}};
        diff     = (ACC_W+1)'(tgt_fix) - (ACC_W+1)'(acc_reg);
        up_new   = !diff[ACC_W] && (diff != '0);
        mag      = up_new ? diff : -diff;
        step_new = mag[ACC_W-1:0] >> shift;
        up_use   = ctrl.load ? up_new : up_reg;
        step_use = ctrl.load ? step_new : step_reg;
    end

    // advance and clamp
    always_comb
    begin
        step_ext = (ACC_W+2)'($signed({2'b00, step_use}));
        tgt_ext  = (ACC_W+2)'(tgt_fix);
        if (up_use)
        begin
            sum  = (ACC_W+2)'(acc_reg) + step_ext;
            done = sum >= tgt_ext;
        end
        else
        begin
            sum  = (ACC_W+2)'(acc_reg) - step_ext;
            done = sum <= tgt_ext;
        end
        acc_next = done ? tgt_fix : sum[ACC_W-1:0];
    end

    assign pos = acc_reg[ACC_W-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            end_reg  <= '0;
            step_reg <= '0;
            up_reg   <= 1'b0;
        end
        else if (ctrl.step_en)
        begin
            acc_reg <= acc_next;
            if (ctrl.load)
            begin
                end_reg  <= target;
                step_reg <= step_new;
                up_reg   <= up_new;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_point_two_axis_interpolator_unit.sv
// Two-axis fixed-point interpolator: one input beat is one output tick and yields exactly
// one result beat. A beat passes an input register, then the aim/step/clamp logic for both
// axes, then the result register; one beat is taken every cycle unless out_stall holds it.
// The position loop (subtract, shift, add, clamp) sets the rate. The user writes
// period_shift through the cfg port while the unit is idle; the block does not enforce it.
`default_nettype none

module fixed_point_two_axis_interpolator_unit
    import fpi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output out_item_t               out_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [SHIFT_W-1:0] cfg_data
);

    logic               s1_valid_reg;
    in_item_t           s1_data_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;
    out_item_t          out_data_next;
    logic [SHIFT_W-1:0] period_shift_reg;
    logic               advance;
    logic               accept;
    axis_ctrl_t         ctrl;
    logic               done_x;
    logic               done_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;

    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign ctrl = '{step_en: advance, load: advance && s1_data_reg.new_target_valid};

    fpi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .target (s1_data_reg.target_x),
        .shift  (period_shift_reg),
        .pos    (pos_x),
        .done   (done_x)
    );

    fpi_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .target (s1_data_reg.target_y),
        .shift  (period_shift_reg),
        .pos    (pos_y),
        .done   (done_y)
    );

    always_comb
    begin
        out_data_next.pos_x   = pos_x;
        out_data_next.pos_y   = pos_y;
        out_data_next.arrived = done_x && done_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            period_shift_reg <= PERIOD_SHIFT_RESET;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                period_shift_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef SYNTHESIS
    a_advance_fills_result: assert property (
        @(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg
    ) else $error("result register not filled after advance");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n) (out_valid_reg && out_stall) |-> !advance
    ) else $error("held result overwritten");

    a_full_accept_drains: assert property (
        @(posedge clk) disable iff (!rst_n) (accept && s1_valid_reg) |-> advance
    ) else $error("input register overwritten");
`endif

endmodule

`default_nettype wire

FILE: tb/fixed_point_two_axis_interpolator_unit_test.sv
`timescale 1ns / 1ps

class interp_scoreboard;
    localparam int FRAC = 16;

    logic [fpi_pkg::SHIFT_W-1:0] shift;
    longint                      pos_x_fix;
    longint                      pos_y_fix;
    longint                      end_x;
    longint                      end_y;
    longint unsigned             step_x;
    longint unsigned             step_y;
    bit                          up_x;
    bit                          up_y;
    fpi_pkg::out_item_t          expected_q[$];
    int                          errors;
    int                          checked;
    int                          arrivals;

    function new();
        shift = fpi_pkg::PERIOD_SHIFT_RESET;
        pos_x_fix = 0;
        pos_y_fix = 0;
        end_x = 0;
        end_y = 0;
        step_x = 0;
        step_y = 0;
        up_x = 1'b0;
        up_y = 1'b0;
        errors = 0;
        checked = 0;
        arrivals = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void aim_axis(input longint pos, input longint goal, output bit up,
                           output longint unsigned step);
        longint          target;
        longint unsigned span;
        target = goal * (longint'(1) <<< FRAC);
        if (target > pos)
        begin
            up = 1'b1;
            span = longint'(target - pos);
        end
        else
        begin
            up = 1'b0;
            span = longint'(pos - target);
        end
        step = span >> shift;
    endfunction

    function bit advance_axis(inout longint pos, input longint goal, input bit up,
                              input longint unsigned step);
        longint target;
        bit     done;
        target = goal * (longint'(1) <<< FRAC);
        if (up)
        begin
            pos = pos + longint'(step);
            done = (pos >= target);
        end
        else
        begin
            pos = pos - longint'(step);
            done = (pos <= target);
        end
        if (done)
            pos = target;
        return done;
    endfunction

    function void note_tick(input fpi_pkg::in_item_t beat);
        fpi_pkg::out_item_t exp_beat;
        bit                 dx;
        bit                 dy;
        if (beat.new_target_valid)
        begin
            end_x = longint'($signed(beat.target_x));
            end_y = longint'($signed(beat.target_y));
            aim_axis(pos_x_fix, end_x, up_x, step_x);
            aim_axis(pos_y_fix, end_y, up_y, step_y);
        end
        exp_beat.pos_x = pos_x_fix[FRAC+15:FRAC];
        exp_beat.pos_y = pos_y_fix[FRAC+15:FRAC];
        dx = advance_axis(pos_x_fix, end_x, up_x, step_x);
        dy = advance_axis(pos_y_fix, end_y, up_y, step_y);
        exp_beat.arrived = dx && dy;
        expected_q.push_back(exp_beat);
    endfunction

    function void check_result(input fpi_pkg::out_item_t got);
        fpi_pkg::out_item_t exp_beat;
        if (expected_q.size() == 0)
        begin
            $error("result beat with nothing expected: pos_x %0d pos_y %0d arrived %0b",
                   got.pos_x, got.pos_y, got.arrived);
            errors++;
            return;
        end
        exp_beat = expected_q.pop_front();
        checked++;
        if (got.arrived === 1'b1)
            arrivals++;
        if (got.pos_x !== exp_beat.pos_x)
        begin
            $error("pos_x: expected %0d, got %0d", exp_beat.pos_x, got.pos_x);
            errors++;
        end
        if (got.pos_y !== exp_beat.pos_y)
        begin
            $error("pos_y: expected %0d, got %0d", exp_beat.pos_y, got.pos_y);
            errors++;
        end
        if (got.arrived !== exp_beat.arrived)
        begin
            $error("arrived: expected %0b, got %0b", exp_beat.arrived, got.arrived);
            errors++;
        end
    endfunction
endclass

module fixed_point_two_axis_interpolator_unit_test;
    import fpi_pkg::*;

    localparam int FRAC = 16;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_item_t           in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [SHIFT_W-1:0] cfg_data = '0;

    interp_scoreboard   sb;
    int                 burst_left = 0;
    int                 gap_max = 0;
    int                 tick_count = 0;
    int                 setting_count = 0;
    logic [POS_W-1:0]   last_x = '0;
    logic [POS_W-1:0]   last_y = '0;
    logic [SHIFT_W-1:0] cur_shift = PERIOD_SHIFT_RESET;
    int                 stall_mode = 0;
    int                 stall_left = 0;
    int                 stall_phase = 0;

    fixed_point_two_axis_interpolator_unit #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver stall pattern, switching at random among four modes
    always @(negedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 120);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_phase % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            sb.check_result(out_data);
    end

    task automatic send_tick(input logic nt, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y);
        in_item_t beat;
        int       gap;
        beat.new_target_valid = nt;
        beat.target_x = x;
        beat.target_y = y;
        if (burst_left == 0)
        begin
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        sb.note_tick(beat);
        burst_left--;
        tick_count++;
        if (nt)
        begin
            last_x = x;
            last_y = y;
        end
    endtask

    task automatic write_shift(input logic [SHIFT_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.shift = value;
        cur_shift = value;
        setting_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] pick_coord(input logic [POS_W-1:0] last);
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return last;
            3: return last + POS_W'($urandom_range(0, 8)) - POS_W'(4);
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic [SHIFT_W-1:0] value, input int n_ticks,
                             input int gaps);
        int start;
        int idle;
        int lim;
        write_shift(value);
        gap_max = gaps;
        start = tick_count;
        while (tick_count - start < n_ticks)
        begin
            if ($urandom_range(0, 9) == 0)
                send_tick(1'($urandom), POS_W'($urandom), POS_W'($urandom));
            else
            begin
                send_tick(1'b1, pick_coord(last_x), pick_coord(last_y));
                lim = (cur_shift > 6) ? 64 : (1 << cur_shift) + 2;
                idle = $urandom_range(0, lim);
                repeat (idle)
                    send_tick(1'b0, POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, starting at the reset shift
        gap_max = 2;
        send_tick(1'b0, 16'hffff, 16'h7fff);
        send_tick(1'b1, 16'h0000, 16'h0000);
        send_tick(1'b1, 16'h7fff, 16'h8000);
        repeat (3) send_tick(1'b0, 16'h04d2, 16'hfb2e);
        send_tick(1'b1, 16'h8000, 16'h7fff);
        repeat (2) send_tick(1'b0, 16'h5555, 16'haaaa);
        send_tick(1'b1, 16'h0001, 16'hffff);
        send_tick(1'b0, 16'haaaa, 16'h5555);

        write_shift(5'd0);
        send_tick(1'b1, 16'h7fff, 16'h7fff);
        send_tick(1'b0, 16'h0000, 16'hffff);
        send_tick(1'b1, 16'h8000, 16'h8000);
        send_tick(1'b0, 16'hffff, 16'h0000);

        // largest shift: tiny steps and stuck axes
        write_shift(5'd31);
        send_tick(1'b1, 16'h7fff, 16'h7fff);
        repeat (2) send_tick(1'b0, 16'h1234, 16'hedcb);
        send_tick(1'b1, 16'h8008, 16'h0000);
        repeat (2) send_tick(1'b0, 16'h0f0f, 16'hf0f0);

        run_phase(5'd1, 170, 6);
        run_phase(5'd16, 170, 0);
        run_phase(5'd4, 170, 6);
        run_phase(5'd0, 170, 0);
        run_phase(5'd20, 170, 6);
        run_phase(5'd2, 170, 0);
        run_phase(5'd5, 170, 6);
        run_phase(5'd31, 170, 0);
        run_phase(5'd3, 170, 6);
        run_phase(5'd6, 170, 0);
        run_phase(5'd8, 170, 6);

        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d ticks sent over %0d shift settings, %0d results checked",
                 tick_count, setting_count + 1, sb.checked);
        $display("%0d results reported both axes on target", sb.arrivals);
        if (sb.errors == 0)
            $display("fixed_point_two_axis_interpolator_unit_test: clean");
        else
            $display("fixed_point_two_axis_interpolator_unit_test: errors");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("fixed_point_two_axis_interpolator_unit_test: errors");
        $finish;
    end
endmodule

FILE: fixed_point_two_axis_interpolator_unit.f
hw/rtl/fpi_pkg.sv
hw/rtl/fpi_axis.sv
hw/rtl/fixed_point_two_axis_interpolator_unit.sv
tb/fixed_point_two_axis_interpolator_unit_test.sv
